/* rtl/ihrc_pkg.sv */
`default_nettype none
package ihrc_pkg;

  // one header word with its framing
  typedef struct packed {
    logic        start_of_header;
    logic [15:0] header_word;
    logic [15:0] ether_type;
  } ihrc_in_t;

  // one verdict per complete header
  typedef struct packed {
    logic [2:0] verdict;
    logic [5:0] header_bytes;
    logic [7:0] protocol;
  } ihrc_out_t;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  HEADER_WORDS   = 4'd10;
  localparam logic [15:0] SUM_GOOD       = 16'hffff;
  localparam logic [3:0]  MIN_IHL        = 4'd5;
  localparam logic [3:0]  IP_VERSION     = 4'd4;
  localparam logic [3:0]  PROTO_WORD     = 4'd4;

  localparam logic [2:0] VERDICT_ACCEPT      = 3'd0;
  localparam logic [2:0] VERDICT_BAD_TYPE    = 3'd1;
  localparam logic [2:0] VERDICT_BAD_VERSION = 3'd2;
  localparam logic [2:0] VERDICT_SHORT_IHL   = 3'd3;
  localparam logic [2:0] VERDICT_BAD_SUM     = 3'd4;

endpackage
`default_nettype wire

/* rtl/ipv4_header_rx_check.sv */
`default_nettype none
// channel   valid      ready      payload           direction
// hdr       hdr_valid  hdr_ready  hdr  (ihrc_in_t)   in, one header word per request
// res       res_valid  res_ready  res  (ihrc_out_t)  out, one verdict per header
//
// one header word per clock sustained while res is not stalled; the verdict for the
// tenth word passes through the input register, then the result register
// the running sum is one 16-bit add with end-around fold between the registers
// rst is synchronous and clears the header state and both valid flags
// a stall on res backs up through the input register to hdr_ready; while the
// result register waits, no word is processed, but one can still be held
module ipv4_header_rx_check (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               hdr_valid,
  output logic                    hdr_ready,
  input  wire ihrc_pkg::ihrc_in_t hdr,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output ihrc_pkg::ihrc_out_t     res
);
  import ihrc_pkg::*;

  // input register
  logic     in_valid;
  ihrc_in_t in_item;

  // core outputs
  logic      core_done;
  ihrc_out_t core_result;

  // held word moves on when the result register can take whatever it makes
  logic advance;

  assign advance   = in_valid && (!res_valid || res_ready);
  assign hdr_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (hdr_ready) begin
      in_valid <= hdr_valid;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (hdr_ready && hdr_valid) begin
      in_item <= hdr;
    end
  end

  // word count, running sum and captured header fields
  ihrc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (in_item),
    .done   (core_done),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= core_done;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_done) begin
      res <= core_result;
    end
  end

endmodule
`default_nettype wire

/* rtl/ihrc_core.sv */
`default_nettype none
module ihrc_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire ihrc_pkg::ihrc_in_t item,
  output logic                    done,
  output ihrc_pkg::ihrc_out_t     result
);
  import ihrc_pkg::*;

  logic [3:0]  word_count;
  logic [15:0] running_sum;
  logic        type_ok;
  logic [3:0]  version_seen;
  logic [3:0]  ihl_seen;
  logic [7:0]  protocol_seen;

  logic        live;
  logic [3:0]  idx;
  logic [3:0]  word_count_next;
  logic [16:0] raw_sum;
  logic [15:0] running_sum_next;

  // a word without start counts only inside a header
  assign live = item.start_of_header ||
                ((word_count != 4'd0) && (word_count < HEADER_WORDS));
  assign idx  = item.start_of_header ? 4'd0 : word_count;
  assign word_count_next = idx + 4'd1;

  // ones'-complement add, one end-around fold is enough
  assign raw_sum = {1'b0, (item.start_of_header ? 16'h0000 : running_sum)} +
                   {1'b0, item.header_word};
  assign running_sum_next = raw_sum[15:0] + {15'd0, raw_sum[16]};

  assign done = live && (word_count_next == HEADER_WORDS);

  // the last word is never word 0 or the protocol word, so held fields are final
  always_comb begin
    if (!type_ok) begin
      result.verdict = VERDICT_BAD_TYPE;
    end else if (version_seen != IP_VERSION) begin
      result.verdict = VERDICT_BAD_VERSION;
    end else if (ihl_seen < MIN_IHL) begin
      result.verdict = VERDICT_SHORT_IHL;
    end else if (running_sum_next != SUM_GOOD) begin
      result.verdict = VERDICT_BAD_SUM;
    end else begin
      result.verdict = VERDICT_ACCEPT;
    end
    result.header_bytes = {ihl_seen, 2'b00};
    result.protocol     = protocol_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count    <= 4'd0;
      running_sum   <= 16'd0;
      type_ok       <= 1'b0;
      version_seen  <= 4'd0;
      ihl_seen      <= 4'd0;
      protocol_seen <= 8'd0;
    end else if (en && live) begin
      running_sum <= running_sum_next;
      word_count  <= done ? 4'd0 : word_count_next;
      if (item.start_of_header) begin
        type_ok <= (item.ether_type == ETHERTYPE_IPV4);
      end
      if (idx == 4'd0) begin
        version_seen <= item.header_word[15:12];
        ihl_seen     <= item.header_word[11:8];
      end
      if (idx == PROTO_WORD) begin
        protocol_seen <= item.header_word[7:0];
      end
    end
  end

endmodule
`default_nettype wire
